FILE: rtl/core/receiver_grid_rank_mapper_defines.svh
// ------------------------------------------------------------------------
// receiver grid rank mapper assertion macros
// shared concurrent assertion forms for the mapper core
// ------------------------------------------------------------------------
`ifndef RECEIVER_GRID_RANK_MAPPER_DEFINES_SVH
`define RECEIVER_GRID_RANK_MAPPER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RGRM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define RGRM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/rgrm_pkg.sv
// ------------------------------------------------------------------------
// rgrm_pkg
// types and constants shared by the receiver grid rank mapper modules
// ------------------------------------------------------------------------
package rgrm_pkg;

    localparam int NUM_RANKS_DEF     = 1024;
    localparam int MAX_RECEIVERS_DEF = 65536;

    localparam int POS_W   = 32;
    localparam int SPC_W   = 31;
    localparam int CPR_W   = 16;
    localparam int RKY_W   = 11;
    localparam int RANK_W  = 10;
    localparam int CNT_W   = 16;
    localparam int CFG_IDX_W = 3;

    // divider sizing: 2*|d| + s fits 34 bits, 2*s fits 32 bits
    localparam int DIV_NW = 34;
    localparam int DIV_DW = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Y     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_SPACING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CPR_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CPR_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RANKS_Y      = 3'd5;

    typedef struct packed {
        logic clear_en;
        logic load_in;
        logic div1_start;
        logic div2_start;
        logic mul_en;
        logic sum_en;
        logic rd_en;
        logic commit;
    } rgrm_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic div_busy;
        logic out_free;
    } rgrm_sts_t;

endpackage

FILE: rtl/core/receiver_grid_rank_mapper.sv
// ------------------------------------------------------------------------
// receiver_grid_rank_mapper
// maps receiver positions to owning rank, order within rank and local cell
// ------------------------------------------------------------------------
// Input channel s_*: one receiver position (pos_x, pos_y), Q24.8 metres.
// Result channel m_*: rank, order_in_rank, local_i, local_j, out_of_range.
// Config channel cfg_*: register index and data, always ready; write only
// while no transaction is in flight.
// Each input goes through two passes of the per-axis restoring dividers
// (one quotient bit per cycle) and then the multiply, sum, table read and
// commit steps. One item is in flight at a time, so the next input is
// taken the cycle after the result is loaded.
// After reset the counter table is cleared by a sweep over all NUM_RANKS entries
// (1024 by default) during which s_ready is low; config writes still go in.
// The result sits in an output register; a new item is accepted while it
// waits, and if m_ready stays low the finished item holds in the last
// step until the register frees up.
// ------------------------------------------------------------------------
module receiver_grid_rank_mapper #(
    parameter int NUM_RANKS     = rgrm_pkg::NUM_RANKS_DEF,
    parameter int MAX_RECEIVERS = rgrm_pkg::MAX_RECEIVERS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [rgrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgrm_pkg::POS_W-1:0]         cfg_data,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic signed [rgrm_pkg::POS_W-1:0]  s_pos_x,
    input  logic signed [rgrm_pkg::POS_W-1:0]  s_pos_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rgrm_pkg::RANK_W-1:0]        m_rank,
    output logic [rgrm_pkg::CNT_W-1:0]         m_order_in_rank,
    output logic [rgrm_pkg::CPR_W-1:0]         m_local_i,
    output logic [rgrm_pkg::CPR_W-1:0]         m_local_j,
    output logic                               m_out_of_range
);
    import rgrm_pkg::*;

    rgrm_cmd_t cmd;
    rgrm_sts_t sts;

    assign cfg_ready = 1'b1;

    rgrm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    rgrm_datapath #(
        .NUM_RANKS     (NUM_RANKS),
        .MAX_RECEIVERS (MAX_RECEIVERS)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .cfg_valid       (cfg_valid),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_rank          (m_rank),
        .m_order_in_rank (m_order_in_rank),
        .m_local_i       (m_local_i),
        .m_local_j       (m_local_j),
        .m_out_of_range  (m_out_of_range)
    );

endmodule

FILE: rtl/core/rgrm_div.sv
// ------------------------------------------------------------------------
// rgrm_div
// restoring unsigned divider, one quotient bit per cycle
// ------------------------------------------------------------------------
module rgrm_div #(
    parameter int NW = 34,
    parameter int DW = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [NW-1:0] quo,
    output logic [DW-1:0] rem
);
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] den_reg;
    logic [DW:0]   rem_sh;
    logic          ge;

    always_comb begin
        rem_sh   = {rem_reg, quo_reg[NW-1]};
        ge       = rem_sh >= {1'b0, den_reg};
        rem_next = ge ? DW'(rem_sh - {1'b0, den_reg}) : rem_sh[DW-1:0];
        quo_next = {quo_reg[NW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(NW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy = busy_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/core/rgrm_datapath.sv
// ------------------------------------------------------------------------
// rgrm_datapath
// config registers, axis dividers, rank arithmetic, counter table, result
// ------------------------------------------------------------------------
`include "receiver_grid_rank_mapper_defines.svh"

module rgrm_datapath #(
    parameter int NUM_RANKS     = rgrm_pkg::NUM_RANKS_DEF,
    parameter int MAX_RECEIVERS = rgrm_pkg::MAX_RECEIVERS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  rgrm_pkg::rgrm_cmd_t                cmd,
    output rgrm_pkg::rgrm_sts_t                sts,
    input  logic                               cfg_valid,
    input  logic [rgrm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rgrm_pkg::POS_W-1:0]         cfg_data,
    input  logic signed [rgrm_pkg::POS_W-1:0]  s_pos_x,
    input  logic signed [rgrm_pkg::POS_W-1:0]  s_pos_y,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rgrm_pkg::RANK_W-1:0]        m_rank,
    output logic [rgrm_pkg::CNT_W-1:0]         m_order_in_rank,
    output logic [rgrm_pkg::CPR_W-1:0]         m_local_i,
    output logic [rgrm_pkg::CPR_W-1:0]         m_local_j,
    output logic                               m_out_of_range
);
    import rgrm_pkg::*;

    localparam int IDXW  = (NUM_RANKS > 1) ? $clog2(NUM_RANKS) : 1;
    localparam int PROD_W = (DIV_NW - 1) + RKY_W;
    localparam int SUM_W  = PROD_W + 1;
    localparam logic [CNT_W-1:0] CNT_TOP =
        (MAX_RECEIVERS - 1 > 65535) ? {CNT_W{1'b1}} : CNT_W'(MAX_RECEIVERS - 1);

    // configuration
    logic signed [POS_W-1:0] org_x_reg, org_y_reg;
    logic [SPC_W-1:0]        spacing_reg;
    logic [CPR_W-1:0]        cpr_x_reg, cpr_y_reg;
    logic [RKY_W-1:0]        ranks_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            org_x_reg   <= '0;
            org_y_reg   <= '0;
            spacing_reg <= SPC_W'(25600);
            cpr_x_reg   <= CPR_W'(64);
            cpr_y_reg   <= CPR_W'(64);
            ranks_y_reg <= RKY_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_ORIGIN_X:     org_x_reg   <= cfg_data;
                CFG_ORIGIN_Y:     org_y_reg   <= cfg_data;
                CFG_GRID_SPACING: spacing_reg <= cfg_data[SPC_W-1:0];
                CFG_CPR_X:        cpr_x_reg   <= cfg_data[CPR_W-1:0];
                CFG_CPR_Y:        cpr_y_reg   <= cfg_data[CPR_W-1:0];
                CFG_RANKS_Y:      ranks_y_reg <= cfg_data[RKY_W-1:0];
                default: ;
            endcase
        end
    end

    logic [SPC_W-1:0] s_eff;
    logic [CPR_W-1:0] cx_eff, cy_eff;

    assign s_eff  = (spacing_reg == '0) ? SPC_W'(1) : spacing_reg;
    assign cx_eff = (cpr_x_reg == '0) ? CPR_W'(1) : cpr_x_reg;
    assign cy_eff = (cpr_y_reg == '0) ? CPR_W'(1) : cpr_y_reg;

    // offset sign and magnitude at accept
    logic [POS_W:0]   dpx, dnx, dpy, dny;
    logic             sign_x_reg, sign_y_reg;
    logic [POS_W-1:0] mag_x_reg, mag_y_reg;

    always_comb begin
        dpx = {s_pos_x[POS_W-1], s_pos_x} - {org_x_reg[POS_W-1], org_x_reg};
        dnx = {org_x_reg[POS_W-1], org_x_reg} - {s_pos_x[POS_W-1], s_pos_x};
        dpy = {s_pos_y[POS_W-1], s_pos_y} - {org_y_reg[POS_W-1], org_y_reg};
        dny = {org_y_reg[POS_W-1], org_y_reg} - {s_pos_y[POS_W-1], s_pos_y};
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            sign_x_reg <= dpx[POS_W];
            sign_y_reg <= dpy[POS_W];
            mag_x_reg  <= dpx[POS_W] ? dnx[POS_W-1:0] : dpx[POS_W-1:0];
            mag_y_reg  <= dpy[POS_W] ? dny[POS_W-1:0] : dpy[POS_W-1:0];
        end
    end

    // axis dividers: first pass rounds to the cell, second splits into rank/local
    logic              div_start;
    logic [DIV_NW-1:0] num_x, num_y, quo_x, quo_y;
    logic [DIV_DW-1:0] den_x, den_y, rem_x, rem_y;
    logic              busy_x, busy_y;

    assign div_start = cmd.div1_start | cmd.div2_start;

    always_comb begin
        if (cmd.div1_start) begin
            num_x = DIV_NW'({mag_x_reg, 1'b0}) + DIV_NW'(s_eff);
            num_y = DIV_NW'({mag_y_reg, 1'b0}) + DIV_NW'(s_eff);
            den_x = {s_eff, 1'b0};
            den_y = {s_eff, 1'b0};
        end else begin
            num_x = quo_x;
            num_y = quo_y;
            den_x = DIV_DW'(cx_eff);
            den_y = DIV_DW'(cy_eff);
        end
    end

    rgrm_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_x (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_x),
        .den     (den_x),
        .busy    (busy_x),
        .quo     (quo_x),
        .rem     (rem_x)
    );

    rgrm_div #(.NW(DIV_NW), .DW(DIV_DW)) u_div_y (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_y),
        .den     (den_y),
        .busy    (busy_y),
        .quo     (quo_y),
        .rem     (rem_y)
    );

    // a negative offset that rounds to zero is still cell zero
    logic neg_reg;

    always_ff @(posedge aclk) begin
        if (cmd.div2_start) begin
            neg_reg <= (sign_x_reg && (quo_x != '0)) || (sign_y_reg && (quo_y != '0));
        end
    end

    // rank = ipx * ranks_y + ipy
    logic [PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]  rank_full_reg;
    logic              oor_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul_en) begin
            prod_reg <= quo_x[DIV_NW-2:0] * ranks_y_reg;
        end
        if (cmd.sum_en) begin
            rank_full_reg <= SUM_W'(prod_reg) + SUM_W'(quo_y[DIV_NW-2:0]);
            oor_reg       <= neg_reg ||
                             ((SUM_W'(prod_reg) + SUM_W'(quo_y[DIV_NW-2:0])) >=
                              SUM_W'(NUM_RANKS));
        end
    end

    // per-rank counter table, cleared by a sweep after reset
    logic [CNT_W-1:0] cnt_mem [NUM_RANKS];
    logic [IDXW-1:0]  clr_idx_reg;
    logic [CNT_W-1:0] rd_data_reg;
    logic             out_free;
    logic             bump;
    logic             m_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    assign bump = cmd.commit && !oor_reg && (rd_data_reg < CNT_TOP);

    always_ff @(posedge aclk) begin
        if (cmd.clear_en) begin
            cnt_mem[clr_idx_reg] <= '0;
        end else if (bump) begin
            cnt_mem[rank_full_reg[IDXW-1:0]] <= rd_data_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= cnt_mem[rank_full_reg[IDXW-1:0]];
        end
    end

    // result register
    logic [RANK_W-1:0] m_rank_reg;
    logic [CNT_W-1:0]  m_order_reg;
    logic [CPR_W-1:0]  m_local_i_reg, m_local_j_reg;
    logic              m_oor_reg;
    logic              m_fields_zero;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_oor_reg     <= oor_reg;
            m_rank_reg    <= oor_reg ? '0 : rank_full_reg[RANK_W-1:0];
            m_order_reg   <= oor_reg ? '0 : rd_data_reg;
            m_local_i_reg <= oor_reg ? '0 : rem_x[CPR_W-1:0];
            m_local_j_reg <= oor_reg ? '0 : rem_y[CPR_W-1:0];
        end
    end

    assign sts.clear_last = (clr_idx_reg == IDXW'(NUM_RANKS - 1));
    assign sts.div_busy   = busy_x || busy_y;
    assign sts.out_free   = out_free;

    assign m_valid         = m_valid_reg;
    assign m_rank          = m_rank_reg;
    assign m_order_in_rank = m_order_reg;
    assign m_local_i       = m_local_i_reg;
    assign m_local_j       = m_local_j_reg;
    assign m_out_of_range  = m_oor_reg;

    assign m_fields_zero = (m_rank_reg == '0) && (m_order_reg == '0) &&
                           (m_local_i_reg == '0) && (m_local_j_reg == '0);

    `RGRM_ASSERT_IMP(a_commit_free, aclk, aresetn, cmd.commit, out_free, "result overwritten")
    `RGRM_ASSERT_NXT(a_div_started, aclk, aresetn, div_start, busy_x && busy_y, "divider idle")
    `RGRM_ASSERT_IMP(a_reject_zero, aclk, aresetn, m_valid_reg && m_oor_reg, m_fields_zero, "rejected result not cleared")

endmodule

FILE: rtl/core/rgrm_ctrl.sv
// ------------------------------------------------------------------------
// rgrm_ctrl
// sequencer for table clear, division passes, rank arithmetic and commit
// ------------------------------------------------------------------------
module rgrm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output rgrm_pkg::rgrm_cmd_t cmd,
    input  rgrm_pkg::rgrm_sts_t sts
);
    import rgrm_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV1,
        ST_DIV1_WAIT,
        ST_DIV2,
        ST_DIV2_WAIT,
        ST_MUL,
        ST_SUM,
        ST_READ,
        ST_DONE
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:     if (sts.clear_last) state_next = ST_IDLE;
            ST_IDLE:      if (s_valid) state_next = ST_DIV1;
            ST_DIV1:      state_next = ST_DIV1_WAIT;
            ST_DIV1_WAIT: if (!sts.div_busy) state_next = ST_DIV2;
            ST_DIV2:      state_next = ST_DIV2_WAIT;
            ST_DIV2_WAIT: if (!sts.div_busy) state_next = ST_MUL;
            ST_MUL:       state_next = ST_SUM;
            ST_SUM:       state_next = ST_READ;
            ST_READ:      state_next = ST_DONE;
            ST_DONE:      if (sts.out_free) state_next = ST_IDLE;
            default:      state_next = ST_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        cmd            = '0;
        cmd.clear_en   = (state_reg == ST_CLEAR);
        cmd.load_in    = (state_reg == ST_IDLE) && s_valid;
        cmd.div1_start = (state_reg == ST_DIV1);
        cmd.div2_start = (state_reg == ST_DIV2);
        cmd.mul_en     = (state_reg == ST_MUL);
        cmd.sum_en     = (state_reg == ST_SUM);
        cmd.rd_en      = (state_reg == ST_READ);
        cmd.commit     = (state_reg == ST_DONE) && sts.out_free;
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

FILE: verif/receiver_grid_rank_mapper_tb.sv
`timescale 1ns / 100ps
// ------------------------------------------------------------------------
// receiver_grid_rank_mapper_tb
// The mapper's inputs are driven with positions that land on chosen cells
// and ranks, mixed with raw noise and with positions just below the origin.
// A cycle-free model predicts rank, order in rank and local cells for every
// transaction taken in, and each transaction that comes out is checked
// against it. The run covers several grid settings, including zero and
// full-scale register values, and random sender bursts and receiver stalls.
// ------------------------------------------------------------------------
module receiver_grid_rank_mapper_tb;
    import rgrm_pkg::*;

    localparam int NUM_RANKS = NUM_RANKS_DEF;
    localparam int TB_MAX_RECEIVERS = MAX_RECEIVERS_DEF;
    localparam logic [CNT_W-1:0] COUNT_TOP = (TB_MAX_RECEIVERS - 1 > 65535) ?
                                             16'hFFFF : 16'(TB_MAX_RECEIVERS - 1);
    // register indexes the block has no register for
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [RANK_W-1:0] rank;
        logic [CNT_W-1:0]  order_in_rank;
        logic [CPR_W-1:0]  local_i;
        logic [CPR_W-1:0]  local_j;
        logic              out_of_range;
    } mapping_t;

    typedef enum int {READY_OPEN, READY_SHUT, READY_DITHER} ready_style_t;

    class rank_map_checker;
        logic [POS_W-1:0] org_x;
        logic [POS_W-1:0] org_y;
        logic [SPC_W-1:0] spacing;
        logic [CPR_W-1:0] cpr_x;
        logic [CPR_W-1:0] cpr_y;
        logic [RKY_W-1:0] ranks_y;
        logic [CNT_W-1:0] rank_counts [NUM_RANKS];
        mapping_t         expected_maps [$];
        int               fails;

        function new();
            org_x   = '0;
            org_y   = '0;
            spacing = 31'd25600;
            cpr_x   = 16'd64;
            cpr_y   = 16'd64;
            ranks_y = 11'd1;
            fails   = 0;
            foreach (rank_counts[r]) rank_counts[r] = '0;
        endfunction

        function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
            case (idx)
                CFG_ORIGIN_X:     org_x = data;
                CFG_ORIGIN_Y:     org_y = data;
                CFG_GRID_SPACING: spacing = data[SPC_W-1:0];
                CFG_CPR_X:        cpr_x = data[CPR_W-1:0];
                CFG_CPR_Y:        cpr_y = data[CPR_W-1:0];
                CFG_RANKS_Y:      ranks_y = data[RKY_W-1:0];
                default: ;
            endcase
        endfunction

        // offset over spacing, rounded half away from zero; neg marks a negative index
        function logic [63:0] rounded_cells(input logic [POS_W-1:0] pos,
                                            input logic [POS_W-1:0] org, output logic neg);
            logic signed [33:0] d;
            logic [63:0] mag;
            logic [63:0] s;
            logic [63:0] q;
            d = $signed({pos[31], pos[31], pos}) - $signed({org[31], org[31], org});
            s = (spacing == '0) ? 64'd1 : {33'd0, spacing};
            mag = {30'd0, (d[33] ? -d : d)};
            q = (2 * mag + s) / (2 * s);
            neg = d[33] && (q != 0);
            return q;
        endfunction

        function mapping_t map_receiver(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
            logic [63:0] qx, qy, cx, cy, ipx, ipy, rank_full;
            logic negx, negy;
            logic [CNT_W-1:0] seen;
            mapping_t m;
            m = '0;
            qx = rounded_cells(px, org_x, negx);
            qy = rounded_cells(py, org_y, negy);
            if (negx || negy) begin
                m.out_of_range = 1'b1;
                return m;
            end
            cx = (cpr_x == '0) ? 64'd1 : {48'd0, cpr_x};
            cy = (cpr_y == '0) ? 64'd1 : {48'd0, cpr_y};
            ipx = qx / cx;
            ipy = qy / cy;
            rank_full = ipx * {53'd0, ranks_y} + ipy;
            if (rank_full >= 64'(NUM_RANKS)) begin
                m.out_of_range = 1'b1;
                return m;
            end
            seen = rank_counts[rank_full[RANK_W-1:0]];
            if (seen < COUNT_TOP) rank_counts[rank_full[RANK_W-1:0]] = seen + 1'b1;
            m.rank          = rank_full[RANK_W-1:0];
            m.order_in_rank = seen;
            m.local_i       = 16'(qx - ipx * cx);
            m.local_j       = 16'(qy - ipy * cy);
            return m;
        endfunction

        function void note_receiver(input logic [POS_W-1:0] px, input logic [POS_W-1:0] py);
            expected_maps.push_back(map_receiver(px, py));
        endfunction

        function int pending();
            return expected_maps.size();
        endfunction

        function void check_mapping(input mapping_t got);
            mapping_t want;
            if (expected_maps.size() == 0) begin
                $display("%0t: result with nothing pending, expected none, actual rank %0d oor %0b",
                         $time, got.rank, got.out_of_range);
                fails++;
                return;
            end
            want = expected_maps.pop_front();
            if (got.rank !== want.rank) begin
                $display("%0t: rank expected %0d actual %0d", $time, want.rank, got.rank);
                fails++;
            end
            if (got.order_in_rank !== want.order_in_rank) begin
                $display("%0t: order_in_rank expected %0d actual %0d", $time,
                         want.order_in_rank, got.order_in_rank);
                fails++;
            end
            if (got.local_i !== want.local_i) begin
                $display("%0t: local_i expected %0d actual %0d", $time, want.local_i, got.local_i);
                fails++;
            end
            if (got.local_j !== want.local_j) begin
                $display("%0t: local_j expected %0d actual %0d", $time, want.local_j, got.local_j);
                fails++;
            end
            if (got.out_of_range !== want.out_of_range) begin
                $display("%0t: out_of_range expected %0b actual %0b", $time,
                         want.out_of_range, got.out_of_range);
                fails++;
            end
        endfunction
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [POS_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [POS_W-1:0]     s_pos_x = '0;
    logic [POS_W-1:0]     s_pos_y = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [RANK_W-1:0]    m_rank;
    logic [CNT_W-1:0]     m_order_in_rank;
    logic [CPR_W-1:0]     m_local_i;
    logic [CPR_W-1:0]     m_local_j;
    logic                 m_out_of_range;

    rank_map_checker mapping_book = new();

    int           burst_left = 0;
    int           ready_hold = 0;
    ready_style_t ready_style = READY_SHUT;
    mapping_t     got_map;

    receiver_grid_rank_mapper #(
        .NUM_RANKS(NUM_RANKS),
        .MAX_RECEIVERS(TB_MAX_RECEIVERS)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_pos_x(s_pos_x),
        .s_pos_y(s_pos_y),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_rank(m_rank),
        .m_order_in_rank(m_order_in_rank),
        .m_local_i(m_local_i),
        .m_local_j(m_local_j),
        .m_out_of_range(m_out_of_range)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

    // result side: check each transaction, then pick the next ready level
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            got_map.rank          = m_rank;
            got_map.order_in_rank = m_order_in_rank;
            got_map.local_i       = m_local_i;
            got_map.local_j       = m_local_j;
            got_map.out_of_range  = m_out_of_range;
            mapping_book.check_mapping(got_map);
        end
        if (ready_hold == 0) begin
            ready_style = ready_style_t'($urandom_range(0, 2));
            case (ready_style)
                READY_OPEN: ready_hold = $urandom_range(30, 300);
                READY_SHUT: ready_hold = $urandom_range(1, 25);
                default:    ready_hold = $urandom_range(20, 100);
            endcase
        end else begin
            ready_hold--;
        end
        case (ready_style)
            READY_OPEN: m_ready <= 1'b1;
            READY_SHUT: m_ready <= 1'b0;
            default:    m_ready <= 1'($urandom_range(0, 1));
        endcase
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [POS_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        mapping_book.set_reg(idx, data);
    endtask

    // one transaction; valid stays up through a burst, drops for a gap after it
    task automatic send_pos(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        int gap;
        s_valid <= 1'b1;
        s_pos_x <= x;
        s_pos_y <= y;
        do @(posedge aclk); while (!s_ready);
        mapping_book.note_receiver(x, y);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = $urandom_range(0, 90);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(0, 20);
        end
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (mapping_book.pending() != 0) @(posedge aclk);
    endtask

    // position near cell q, jittered up to half a cell either way
    function automatic logic [POS_W-1:0] place(input logic [POS_W-1:0] org,
                                               input longint s, input longint q);
        longint hs, jit, p;
        hs = s / 2;
        case ($urandom_range(0, 5))
            0: jit = hs;
            1: jit = -hs;
            2: jit = 0;
            default: jit = longint'($urandom_range(0, 32'(2 * hs))) - hs;
        endcase
        p = longint'($signed(org)) + q * s + jit;
        return p[31:0];
    endfunction

    task automatic run_phase(input logic [POS_W-1:0] ox, input logic [POS_W-1:0] oy,
                             input logic [POS_W-1:0] sp, input logic [POS_W-1:0] cx,
                             input logic [POS_W-1:0] cy, input logic [POS_W-1:0] ry,
                             input int cap, input int n_items);
        longint se, cxe, cye, qx, qy;
        int rye, ipx_lim, ipy_lim, kind;
        logic [POS_W-1:0] x, y;
        settle();
        write_reg(CFG_ORIGIN_X, ox);
        write_reg(CFG_ORIGIN_Y, oy);
        write_reg(CFG_GRID_SPACING, sp);
        write_reg(CFG_CPR_X, cx);
        write_reg(CFG_CPR_Y, cy);
        write_reg(CFG_RANKS_Y, ry);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());
        cfg_valid <= 1'b0;
        se  = (sp[SPC_W-1:0] == '0) ? 64'sd1 : longint'(sp[SPC_W-1:0]);
        cxe = (cx[CPR_W-1:0] == '0) ? 64'sd1 : longint'(cx[CPR_W-1:0]);
        cye = (cy[CPR_W-1:0] == '0) ? 64'sd1 : longint'(cy[CPR_W-1:0]);
        rye = int'(ry[RKY_W-1:0]);
        if (rye == 0) begin
            ipx_lim = 100;
            ipy_lim = NUM_RANKS;
        end else begin
            // one step past the table edge so some ranks fall just outside it
            ipx_lim = NUM_RANKS / rye;
            ipy_lim = (rye > NUM_RANKS) ? NUM_RANKS : rye;
        end
        if (cap >= 0) begin
            if (ipx_lim > cap) ipx_lim = cap;
            if (ipy_lim > cap) ipy_lim = cap;
        end
        repeat (n_items) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                x = $urandom();
                y = $urandom();
            end else begin
                qx = longint'($urandom_range(0, ipx_lim)) * cxe
                     + longint'($urandom_range(0, 32'(cxe - 1)));
                qy = longint'($urandom_range(0, ipy_lim)) * cye
                     + longint'($urandom_range(0, 32'(cye - 1)));
                if (kind == 1) qx = -longint'($urandom_range(1, 4));
                if (kind == 2) qy = -longint'($urandom_range(1, 4));
                x = place(ox, se, qx);
                y = place(oy, se, qy);
            end
            send_pos(x, y);
        end
    endtask

    initial begin
        logic [POS_W-1:0] rox, roy, rsp, rcx, rcy, rry;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(0, 20);

        // reset settings: 100 m cells, 64x64 cells per rank, one rank along y
        send_pos(32'd0, 32'd0);
        send_pos(32'd0, 32'd0);
        send_pos(32'd12799, 32'd12800);
        send_pos(32'd12800, 32'd12799);
        send_pos(-32'sd12799, 32'd0);
        send_pos(-32'sd12800, 32'd0);
        send_pos(32'd0, -32'sd12800);
        send_pos(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pos(32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_pos(32'h8000_0000, 32'h8000_0000);
        send_pos(32'h7FFF_FFFF, 32'd0);
        send_pos(32'd0, 32'h8000_0000);
        // last rank in the table and the first one past it
        send_pos(32'd1676083200, 32'd0);
        send_pos(32'd1677721600, 32'd0);
        send_pos(32'd0, 32'd1677721600);
        // top local cell on both axes
        send_pos(32'd1612800, 32'd9804800);
        send_pos(32'd1612800, 32'd9804800);
        send_pos(32'd0, 32'd0);

        run_phase(32'd0, 32'd0, 32'd256, 32'd16, 32'd16, 32'd32, -1, 200);
        // zero spacing, cells and stride, packed onto two ranks
        run_phase(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 1, 250);
        run_phase(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  32'h0001_0001, 32'hFFFF_FFFF, -1, 100);
        run_phase(32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd1, 32'd65535, 32'd1, -1, 100);

        for (int p = 0; p < 8; p++) begin
            rox = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4000000) - 2000000;
            roy = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 4000000) - 2000000;
            case ($urandom_range(0, 3))
                0:       rsp = $urandom();
                1:       rsp = $urandom_range(1, 200000);
                default: rsp = $urandom_range(1, 2000);
            endcase
            rcx = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 300);
            rcy = ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(1, 300);
            case ($urandom_range(0, 3))
                0:       rry = $urandom();
                1:       rry = $urandom_range(0, 2047);
                default: rry = $urandom_range(1, 40);
            endcase
            run_phase(rox, roy, rsp, rcx, rcy, rry, -1, 150);
        end

        settle();
        repeat (100) @(posedge aclk);
        if (mapping_book.fails == 0 && mapping_book.pending() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
